// ===== hdl/pcd_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the path conflict detector
package pcd_pkg;

  localparam int AGENT_W = 6;
  localparam int WIN_W   = 16;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_EDGE   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic read_en;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
  } status_t;

endpackage

// ===== hdl/pcd_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine of the path conflict detector
module pcd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  pcd_pkg::status_t status_i,
  output pcd_pkg::cmd_t    cmd_o,
  output logic             busy
);

  pcd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.read_en = 1'b0;
    cmd_o.finish  = 1'b0;
    case (state_q)
      pcd_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = pcd_pkg::S_SCAN;
        end
      end
      pcd_pkg::S_SCAN: begin
        if (status_i.skip) begin
          state_d = pcd_pkg::S_FINISH;
        end else begin
          cmd_o.read_en = 1'b1;
          if (status_i.last) begin
            state_d = pcd_pkg::S_DRAIN;
          end
        end
      end
      pcd_pkg::S_DRAIN: begin
        state_d = pcd_pkg::S_FINISH;
      end
      pcd_pkg::S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = pcd_pkg::S_IDLE;
      end
      default: begin
        state_d = pcd_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != pcd_pkg::S_IDLE);

endmodule

// ===== hdl/pcd_dp.sv =====
`timescale 1ns / 1ps
// datapath of the path conflict detector: move table, compare and result registers
module pcd_dp #(
  parameter int MAX_AGENTS = 64,
  parameter int COORD_BITS = 16,
  parameter int STEP_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcd_pkg::cmd_t               cmd_i,
  output pcd_pkg::status_t            status_o,
  input  logic                        cfg_we_i,
  input  logic [pcd_pkg::WIN_W-1:0]   cfg_wdata_i,
  input  logic [pcd_pkg::AGENT_W-1:0] agent_id_i,
  input  logic [STEP_BITS-1:0]        timestep_i,
  input  logic [COORD_BITS-1:0]       prev_x_i,
  input  logic [COORD_BITS-1:0]       prev_y_i,
  input  logic [COORD_BITS-1:0]       cur_x_i,
  input  logic [COORD_BITS-1:0]       cur_y_i,
  input  logic                        end_of_step_i,
  input  logic                        end_of_set_i,
  output logic                        valid_o,
  output logic                        found_o,
  output logic                        conflict_kind_o,
  output logic [pcd_pkg::AGENT_W-1:0] first_agent_o,
  output logic [pcd_pkg::AGENT_W-1:0] second_agent_o,
  output logic [STEP_BITS-1:0]        conflict_step_o,
  output logic [COORD_BITS-1:0]       point_a_x_o,
  output logic [COORD_BITS-1:0]       point_a_y_o,
  output logic [COORD_BITS-1:0]       point_b_x_o,
  output logic [COORD_BITS-1:0]       point_b_y_o,
  output logic                        table_overflow_o
);

  localparam int IDX_W = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CNT_W = $clog2(MAX_AGENTS + 1);
  localparam int CMP_W = (STEP_BITS > pcd_pkg::WIN_W) ? STEP_BITS : pcd_pkg::WIN_W;

  typedef struct packed {
    logic [COORD_BITS-1:0]       px;
    logic [COORD_BITS-1:0]       py;
    logic [COORD_BITS-1:0]       cx;
    logic [COORD_BITS-1:0]       cy;
    logic [pcd_pkg::AGENT_W-1:0] owner;
  } entry_t;

  entry_t mem [MAX_AGENTS];
  entry_t rdata_q;

  logic [pcd_pkg::WIN_W-1:0]   win_q;
  logic [pcd_pkg::AGENT_W-1:0] agent_q;
  logic [STEP_BITS-1:0]        ts_q;
  logic [COORD_BITS-1:0]       px_q, py_q, cx_q, cy_q;
  logic                        eos_q, eoset_q, check_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [IDX_W-1:0]            idx_q;
  logic                        rvalid_q;
  logic                        vhit_q, ehit_q;
  logic [pcd_pkg::AGENT_W-1:0] vown_q, eown_q;
  logic                        latched_q, ovf_q, valid_q;

  logic check_d, vmatch, ematch, hit, room, record, ovf_now, emit_none;
  entry_t wdata;

  // window test on the incoming move
  assign check_d = !latched_q && (timestep_i != '0) &&
                   ((win_q == '0) || (CMP_W'(timestep_i) < CMP_W'(win_q)));

  assign status_o.skip = !check_q || (cnt_q == '0);
  assign status_o.last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);

  assign vmatch = rvalid_q && (rdata_q.cx == cx_q) && (rdata_q.cy == cy_q);
  assign ematch = rvalid_q && (rdata_q.px == cx_q) && (rdata_q.py == cy_q) &&
                  (rdata_q.cx == px_q) && (rdata_q.cy == py_q);

  assign hit       = vhit_q || ehit_q;
  assign room      = (cnt_q != CNT_W'(MAX_AGENTS));
  assign record    = check_q && !hit && room;
  assign ovf_now   = check_q && !hit && !room;
  assign emit_none = eoset_q && !hit && !latched_q;

  assign wdata.px    = px_q;
  assign wdata.py    = py_q;
  assign wdata.cx    = cx_q;
  assign wdata.cy    = cy_q;
  assign wdata.owner = agent_q;

  // table memory, one read port for the scan, one write port for recording
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && record) begin
      mem[cnt_q[IDX_W-1:0]] <= wdata;
    end
    if (cmd_i.read_en) begin
      rdata_q <= mem[idx_q];
    end
  end

  // move registers and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      agent_q <= agent_id_i;
      ts_q    <= timestep_i;
      px_q    <= prev_x_i;
      py_q    <= prev_y_i;
      cx_q    <= cur_x_i;
      cy_q    <= cur_y_i;
      eos_q   <= end_of_step_i;
      eoset_q <= end_of_set_i;
      check_q <= check_d;
    end
    if (vmatch && !vhit_q) begin
      vown_q <= rdata_q.owner;
    end
    if (ematch && !ehit_q) begin
      eown_q <= rdata_q.owner;
    end
    if (cmd_i.finish) begin
      found_o          <= hit;
      conflict_kind_o  <= vhit_q ? pcd_pkg::KIND_VERTEX :
                          (ehit_q ? pcd_pkg::KIND_EDGE : pcd_pkg::KIND_VERTEX);
      first_agent_o    <= hit ? (vhit_q ? vown_q : eown_q) : '0;
      second_agent_o   <= hit ? agent_q : '0;
      conflict_step_o  <= hit ? ts_q : '0;
      point_a_x_o      <= hit ? cx_q : '0;
      point_a_y_o      <= hit ? cy_q : '0;
      point_b_x_o      <= hit ? (vhit_q ? cx_q : px_q) : '0;
      point_b_y_o      <= hit ? (vhit_q ? cy_q : py_q) : '0;
      table_overflow_o <= ovf_q || ovf_now;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      rvalid_q  <= 1'b0;
      vhit_q    <= 1'b0;
      ehit_q    <= 1'b0;
      latched_q <= 1'b0;
      ovf_q     <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      rvalid_q <= cmd_i.read_en;
      valid_q  <= cmd_i.finish && (hit || emit_none);
      if (cmd_i.load) begin
        idx_q  <= '0;
        vhit_q <= 1'b0;
        ehit_q <= 1'b0;
      end else begin
        if (cmd_i.read_en) begin
          idx_q <= idx_q + IDX_W'(1);
        end
        if (vmatch) begin
          vhit_q <= 1'b1;
        end
        if (ematch) begin
          ehit_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (eoset_q) begin
          latched_q <= 1'b0;
          ovf_q     <= 1'b0;
        end else begin
          if (hit) begin
            latched_q <= 1'b1;
          end
          if (ovf_now) begin
            ovf_q <= 1'b1;
          end
        end
        if (eoset_q || eos_q) begin
          cnt_q <= '0;
        end else if (record) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== hdl/path_conflict_detector.sv =====
`timescale 1ns / 1ps
// top level of the path conflict detector
//
// moves enter one beat at a time on start while busy is low, in timestep-major,
// agent-minor order. every move is compared against the cell and edge entries
// recorded so far in the current timestep; those entries sit in one table memory
// of MAX_AGENTS words that is scanned through its single read port, one entry
// per clock. a move therefore keeps busy high after it is taken through the
// scan, a drain state for the last read to land and a decide state; an
// unchecked move or an empty table skips the reads and the drain.
// there is no back pressure on the result side: a result beat is held on the
// output ports for exactly one cycle, marked by valid_o, the cycle after the
// move is decided, and must be captured then. at most one result comes per
// move: the first conflict of a set, or a no-conflict beat on the end_of_set
// move of a clean set. table_overflow_o reports whether some timestep of the
// set had more moves than table entries. no clearing pass is needed after
// reset: the table is tracked by its fill count. window_limit must be written
// via cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
module path_conflict_detector #(
  parameter int MAX_AGENTS = 64,
  parameter int COORD_BITS = 16,
  parameter int STEP_BITS  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // window_limit register
  input  logic                        cfg_we_i,
  input  logic [pcd_pkg::WIN_W-1:0]   cfg_wdata_i,
  // move command
  input  logic                        start,
  output logic                        busy,
  input  logic [pcd_pkg::AGENT_W-1:0] agent_id_i,
  input  logic [STEP_BITS-1:0]        timestep_i,
  input  logic [COORD_BITS-1:0]       prev_x_i,
  input  logic [COORD_BITS-1:0]       prev_y_i,
  input  logic [COORD_BITS-1:0]       cur_x_i,
  input  logic [COORD_BITS-1:0]       cur_y_i,
  input  logic                        end_of_step_i,
  input  logic                        end_of_set_i,
  // result beat
  output logic                        valid_o,
  output logic                        found_o,
  output logic                        conflict_kind_o,
  output logic [pcd_pkg::AGENT_W-1:0] first_agent_o,
  output logic [pcd_pkg::AGENT_W-1:0] second_agent_o,
  output logic [STEP_BITS-1:0]        conflict_step_o,
  output logic [COORD_BITS-1:0]       point_a_x_o,
  output logic [COORD_BITS-1:0]       point_a_y_o,
  output logic [COORD_BITS-1:0]       point_b_x_o,
  output logic [COORD_BITS-1:0]       point_b_y_o,
  output logic                        table_overflow_o
);

  pcd_pkg::cmd_t    cmd;
  pcd_pkg::status_t status;

  // sequencing: accept, scan, drain the last read, decide
  pcd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // table, compare logic, set-level flags and result registers
  pcd_dp #(
    .MAX_AGENTS (MAX_AGENTS),
    .COORD_BITS (COORD_BITS),
    .STEP_BITS  (STEP_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .agent_id_i       (agent_id_i),
    .timestep_i       (timestep_i),
    .prev_x_i         (prev_x_i),
    .prev_y_i         (prev_y_i),
    .cur_x_i          (cur_x_i),
    .cur_y_i          (cur_y_i),
    .end_of_step_i    (end_of_step_i),
    .end_of_set_i     (end_of_set_i),
    .valid_o          (valid_o),
    .found_o          (found_o),
    .conflict_kind_o  (conflict_kind_o),
    .first_agent_o    (first_agent_o),
    .second_agent_o   (second_agent_o),
    .conflict_step_o  (conflict_step_o),
    .point_a_x_o      (point_a_x_o),
    .point_a_y_o      (point_a_y_o),
    .point_b_x_o      (point_b_x_o),
    .point_b_y_o      (point_b_y_o),
    .table_overflow_o (table_overflow_o)
  );

  // a result beat only follows a decide cycle
  a_valid_after_finish : assert property (
    @(posedge clk_i) disable iff (!rst_ni) valid_o |-> $past(cmd.finish)
  ) else $error("result beat without a decided move");

  // an accepted move keeps the block busy
  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy
  ) else $error("busy not raised after accepting a move");

  // commands are mutually exclusive, and only load happens while idle
  a_cmd_exclusive : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      $onehot0({cmd.load, cmd.read_en, cmd.finish}) &&
      ((cmd.read_en || cmd.finish) ? busy : 1'b1)
  ) else $error("illegal command combination");

  // a no-conflict beat carries zero fields
  a_clean_report_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_o && !found_o) |-> (conflict_kind_o == pcd_pkg::KIND_VERTEX &&
                                 first_agent_o == '0 && second_agent_o == '0 &&
                                 conflict_step_o == '0 && point_a_x_o == '0 &&
                                 point_b_y_o == '0)
  ) else $error("no-conflict beat with nonzero fields");

endmodule
